[hw/rtl/wsd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
// Used by wsd_front, wsd_queue, wsd_back and websocket_frame_deframer.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR1    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CLOSED  = 3'd5,
    PH_DEAD    = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_PING     = 3'd1,
    KIND_CLOSE    = 3'd2,
    KIND_RSV      = 3'd3,
    KIND_UNMASKED = 3'd4
  } kind_e;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;

  // One classified beat handed from the parser to the output side.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       byte_valid;
    kind_e      kind;
    logic       last;
  } wsd_entry_t;

endpackage

[hw/rtl/wsd_front.sv]
// Header parser: walks the frame header, length and mask key, and
// classifies received bytes into queue entries. Depends on wsd_pkg.
module wsd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              space_i,
  output logic              push_o,
  output wsd_pkg::wsd_entry_t entry_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [2:0]  fbc_q, fbc_d;
  logic [63:0] ext_q, ext_d;
  logic [31:0] key_q, key_d;
  logic [63:0] rem_q, rem_d;
  logic [1:0]  midx_q, midx_d;

  logic        accept;
  logic        deliver;
  kind_e       op_kind;
  logic [7:0]  key_byte;
  logic [63:0] ext_shift;
  phase_e      end_phase;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;
  assign ext_shift  = {ext_q[55:0], data_byte_i};
  assign end_phase  = (opcode_q == OP_CLOSE) ? PH_CLOSED : PH_HDR1;

  always_comb begin
    deliver = 1'b1;
    op_kind = KIND_DATA;
    case (opcode_q)
      OP_CONT, OP_TEXT, OP_BINARY: op_kind = KIND_DATA;
      OP_PING:                     op_kind = KIND_PING;
      OP_CLOSE:                    op_kind = KIND_CLOSE;
      default:                     deliver = 1'b0;
    endcase
  end

  always_comb begin
    case (midx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    fbc_d    = fbc_q;
    ext_d    = ext_q;
    key_d    = key_q;
    rem_d    = rem_q;
    midx_d   = midx_q;
    push_o   = 1'b0;
    entry_o  = '{data: 8'd0, key: 8'd0, byte_valid: 1'b0, kind: KIND_DATA, last: 1'b1};
    if (accept) begin
      case (phase_q)
        PH_HDR1: begin
          opcode_d = data_byte_i[3:0];
          fbc_d    = data_byte_i[6:4];
          phase_d  = PH_HDR2;
        end
        PH_HDR2: begin
          if (fbc_q != 3'd0 || !data_byte_i[7]) begin
            push_o        = 1'b1;
            entry_o.kind  = (fbc_q != 3'd0) ? KIND_RSV : KIND_UNMASKED;
            phase_d       = PH_DEAD;
          end else begin
            ext_d = '0;
            key_d = '0;
            if (data_byte_i[6:0] < LEN_EXT16) begin
              rem_d   = {57'd0, data_byte_i[6:0]};
              fbc_d   = 3'd0;
              phase_d = PH_MASK;
            end else begin
              fbc_d   = (data_byte_i[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
              phase_d = PH_EXTLEN;
            end
          end
        end
        PH_EXTLEN: begin
          ext_d = ext_shift;
          if (fbc_q == 3'd0) begin
            rem_d   = ext_shift;
            phase_d = PH_MASK;
          end else begin
            fbc_d = fbc_q - 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], data_byte_i};
          fbc_d = fbc_q + 3'd1;
          if (fbc_d[2]) begin
            fbc_d  = 3'd0;
            midx_d = 2'd0;
            if (rem_q != 64'd0) begin
              phase_d = PH_PAYLOAD;
            end else begin
              // empty frame: one closing beat for delivered opcodes
              phase_d      = end_phase;
              push_o       = deliver;
              entry_o.kind = op_kind;
            end
          end
        end
        PH_PAYLOAD: begin
          midx_d = midx_q + 2'd1;
          rem_d  = rem_q - 64'd1;
          if (rem_q == 64'd1) begin
            phase_d = end_phase;
          end
          push_o  = deliver;
          entry_o = '{data: data_byte_i, key: key_byte, byte_valid: 1'b1,
                      kind: op_kind, last: (rem_q == 64'd1)};
        end
        default: begin
          // closed or dead: drop the byte
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR1;
      opcode_q <= '0;
      fbc_q    <= '0;
      ext_q    <= '0;
      key_q    <= '0;
      rem_q    <= '0;
      midx_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fbc_q    <= fbc_d;
      ext_q    <= ext_d;
      key_q    <= key_d;
      rem_q    <= rem_d;
      midx_q   <= midx_d;
    end
  end

endmodule

[hw/rtl/wsd_queue.sv]
// Small FIFO of classified beats between the parser and the output stage.
// Depends on wsd_pkg for the entry type.
module wsd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wsd_pkg::wsd_entry_t entry_i,
  output logic                space_o,
  input  logic                pop_i,
  output logic                nempty_o,
  output wsd_pkg::wsd_entry_t entry_o
);
  import wsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wsd_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign space_o  = (cnt_q != CntW'(Depth));
  assign nempty_o = (cnt_q != '0);
  assign do_push  = push_i && space_o;
  assign do_pop   = pop_i && nempty_o;
  assign entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[hw/rtl/wsd_back.sv]
// Output stage: pulls beats from the queue, unmasks payload bytes and
// holds the result in the output register. Depends on wsd_pkg.
module wsd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                nempty_i,
  input  wsd_pkg::wsd_entry_t entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                byte_valid_o,
  output logic [2:0]          kind_o,
  output logic                last_o
);
  import wsd_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       bvalid_q, bvalid_d;
  kind_e      kind_q, kind_d;
  logic       last_q, last_d;

  // load a new beat when the register is empty or being drained
  assign pop_o = nempty_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d  = valid_q;
    byte_d   = byte_q;
    bvalid_d = bvalid_q;
    kind_d   = kind_q;
    last_d   = last_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (pop_o) begin
      valid_d  = 1'b1;
      byte_d   = entry_i.byte_valid ? (entry_i.data ^ entry_i.key) : 8'd0;
      bvalid_d = entry_i.byte_valid;
      kind_d   = entry_i.kind;
      last_d   = entry_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    bvalid_q <= bvalid_d;
    kind_q   <= kind_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bvalid_q;
  assign kind_o       = kind_q;
  assign last_o       = last_q;

endmodule

[hw/rtl/websocket_frame_deframer.sv]
// Client-to-server WebSocket deframer: one received byte per beat, one byte
// per cycle sustained while the queue has space. The parser consumes every
// byte in the cycle it is accepted; results are registered in a QDepth-entry
// queue and then in an output register, and the input only stalls when the
// queue is full because the output side is held. Header, length and mask key
// bytes give no result, except that a reserved-bit or unmasked error and the
// last key byte of an empty data, ping or close frame each give one bare last
// beat. Reserved-bit or unmasked errors and completed close frames latch until
// reset. Depends on wsd_pkg, wsd_front, wsd_queue and wsd_back.
module websocket_frame_deframer #(
  parameter int unsigned QDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [2:0] kind_o,
  output logic       last_o
);
  import wsd_pkg::*;

  logic       space;
  logic       push;
  logic       pop;
  logic       nempty;
  wsd_entry_t front_entry;
  wsd_entry_t queue_entry;

  wsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_byte_i(data_byte_i),
    .space_i    (space),
    .push_o     (push),
    .entry_o    (front_entry)
  );

  wsd_queue #(
    .Depth(QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .space_o (space),
    .pop_i   (pop),
    .nempty_o(nempty),
    .entry_o (queue_entry)
  );

  wsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nempty_i    (nempty),
    .entry_i     (queue_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .kind_o      (kind_o),
    .last_o      (last_o)
  );

endmodule
